[rtl/tfnp_pkg.sv]
// Shared types and constants for the four-field nibble packer.
package tfnp_pkg;

	localparam int unsigned N_FIELDS = 4;
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned STREAM_W = N_FIELDS * FIELD_W;

	// Size class of one field, as it appears in the selector byte.
	typedef enum logic [1:0] {
		CODE_ZERO  = 2'd0,
		CODE_NIB4  = 2'd1,
		CODE_NIB8  = 2'd2,
		CODE_NIB16 = 2'd3
	} code_t;

	// What one lane found for its field.
	typedef struct packed {
		code_t        code;
		logic [2:0]   nib_count;
		logic [15:0]  nibs;
	} lane_t;

	// One item after merging, ready for serialisation.
	typedef struct packed {
		logic [7:0]          sel;
		logic [STREAM_W-1:0] stream;
		logic [3:0]          nbytes;
	} merged_t;

endpackage

[rtl/tfnp_lane.sv]
// Classifies one signed field and left-aligns its significant nibbles.
module tfnp_lane (
	input  logic [15:0]     field,
	output tfnp_pkg::lane_t lane
);

	logic fits4;
	logic fits8;

	// A value fits n bits when all bits from the sign bit of n upwards agree.
	assign fits4 = (field[15:3] == '0) || (field[15:3] == '1);
	assign fits8 = (field[15:7] == '0) || (field[15:7] == '1);

	always_comb begin
		if (field == '0) begin
			lane.code      = tfnp_pkg::CODE_ZERO;
			lane.nib_count = 3'd0;
			lane.nibs      = '0;
		end else if (fits4) begin
			lane.code      = tfnp_pkg::CODE_NIB4;
			lane.nib_count = 3'd1;
			lane.nibs      = {field[3:0], 12'd0};
		end else if (fits8) begin
			lane.code      = tfnp_pkg::CODE_NIB8;
			lane.nib_count = 3'd2;
			lane.nibs      = {field[7:0], 8'd0};
		end else begin
			lane.code      = tfnp_pkg::CODE_NIB16;
			lane.nib_count = 3'd4;
			lane.nibs      = field;
		end
	end

endmodule

[rtl/tfnp_merge.sv]
// Combines the four lane results into a selector and one nibble stream.
module tfnp_merge (
	input  tfnp_pkg::lane_t   lanes [tfnp_pkg::N_FIELDS],
	output tfnp_pkg::merged_t merged
);

	localparam int unsigned SW = tfnp_pkg::STREAM_W;

	logic [3:0]    off1;
	logic [3:0]    off2;
	logic [3:0]    off3;
	logic [4:0]    total;
	logic [4:0]    total_rnd;
	logic [SW-1:0] part0;
	logic [SW-1:0] part1;
	logic [SW-1:0] part2;
	logic [SW-1:0] part3;

	// Nibble offset of each field in the stream is the running sum of counts.
	assign off1  = {1'b0, lanes[0].nib_count};
	assign off2  = off1 + {1'b0, lanes[1].nib_count};
	assign off3  = off2 + {1'b0, lanes[2].nib_count};
	assign total = {1'b0, off3} + {2'b00, lanes[3].nib_count};

	// The earliest nibble sits in the top bits; unused low bits stay zero,
	// which also supplies the zero half of a flushed odd nibble.
	assign part0 = {lanes[0].nibs, {(SW-16){1'b0}}};
	assign part1 = {lanes[1].nibs, {(SW-16){1'b0}}} >> {off1, 2'b00};
	assign part2 = {lanes[2].nibs, {(SW-16){1'b0}}} >> {off2, 2'b00};
	assign part3 = {lanes[3].nibs, {(SW-16){1'b0}}} >> {off3, 2'b00};

	assign total_rnd     = total + 5'd1;
	assign merged.stream = part0 | part1 | part2 | part3;
	assign merged.sel    = {lanes[3].code, lanes[2].code, lanes[1].code, lanes[0].code};
	assign merged.nbytes = 4'd1 + total_rnd[4:1];

endmodule

[rtl/tag8_four_field_nibble_packer.sv]
// Top level of the four-field tagged nibble packer.
// Each accepted input transaction carries four signed 16-bit fields and produces
// between one and nine output transactions of one byte each: first the selector
// byte holding a 2-bit size class per field (field0 in the low bits), then the
// non-zero fields packed most significant nibble first, two nibbles per byte,
// with a trailing odd nibble flushed in the high half of a final byte. The last
// byte of every item is marked with m_tlast. Items leave through the byte-wide
// output register; an accepted input passes the lane register and then the
// output register before its first byte is offered. Input transactions are taken
// while earlier items are still being emitted, through a lane stage and a merge
// stage in front of the output register.
module tag8_four_field_nibble_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // field0 [15:0], field1 [31:16], field2 [47:32], field3 [63:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte [7:0]
	output logic        m_tlast   // last_byte
);

	localparam int unsigned FC = tfnp_pkg::N_FIELDS;
	localparam int unsigned SW = tfnp_pkg::STREAM_W;

	tfnp_pkg::lane_t   lane_d [FC];
	tfnp_pkg::lane_t   lane_s1 [FC];
	tfnp_pkg::merged_t merged;

	logic          valid_s1;
	logic          valid_s2;
	logic [7:0]    sel_s2;
	logic [SW-1:0] stream_s2;
	logic [3:0]    nbytes_s2;
	logic [3:0]    idx_q;

	logic in_fire;
	logic out_fire;
	logic s2_free;
	logic move_s1;

	// One lane per field: each classifies its field independently.
	for (genvar g = 0; g < FC; g++) begin : g_lane
		tfnp_lane u_lane (
			.field (s_tdata[g*16 +: 16]),
			.lane  (lane_d[g])
		);
	end

	// The merge stage works on the registered lane results.
	tfnp_merge u_merge (
		.lanes  (lane_s1),
		.merged (merged)
	);

	// The output stage frees itself in the same cycle as its last byte is taken,
	// so a queued item follows without a gap.
	assign out_fire = m_tvalid && m_tready;
	assign s2_free  = !valid_s2 || (out_fire && m_tlast);
	assign move_s1  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			lane_s1 <= lane_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (out_fire) begin
			if (m_tlast) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	// The packed stream shifts up by one byte for every field byte sent, so the
	// next byte is always in the top eight bits.
	always_ff @(posedge clk) begin
		if (move_s1) begin
			sel_s2    <= merged.sel;
			stream_s2 <= merged.stream;
			nbytes_s2 <= merged.nbytes;
		end else if (out_fire && (idx_q != 4'd0)) begin
			stream_s2 <= {stream_s2[SW-9:0], 8'd0};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = (idx_q == 4'd0) ? sel_s2 : stream_s2[SW-1 -: 8];
	assign m_tlast  = (idx_q == (nbytes_s2 - 4'd1));

endmodule

[rtl/tfnp_checker.sv]
// Port-level checks for the nibble packer, bound to its top level.
module tfnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	logic       first_q;
	logic [3:0] count_q;

	// Tracks the start of each item and the bytes sent within it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			count_q <= '0;
		end else if (m_tvalid && m_tready) begin
			first_q <= m_tlast;
			count_q <= m_tlast ? 4'd0 : count_q + 4'd1;
		end
	end

	// A stalled output byte must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output byte changed while stalled");

	// An all-zero selector means the item is that byte alone.
	a_zero_sel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q && (m_tdata == 8'd0) |-> m_tlast)
		else $error("zero selector not marked last");

	// No item is longer than nine bytes.
	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (count_q < 4'd9))
		else $error("item longer than nine bytes");

	// The input only stalls behind a pending output byte.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output pending");

endmodule

bind tag8_four_field_nibble_packer tfnp_checker u_tfnp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
